// ----- rtl/qtl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package qtl_pkg;

   // Position counter width default
   localparam int PositionBitsDefault = 20;

   // Result field widths
   localparam int KindBits    = 5;
   localparam int FieldBits   = 20;
   localparam int MaxTokens   = 3;
   localparam int CountBits   = 2;
   localparam int ReqDataBits = 8;
   localparam int RspDataBits = 48;

   // Bundle queue between the lexer front and the token back end
   localparam int QueueDepth    = 4;
   localparam int QueuePtrBits  = $clog2(QueueDepth);
   localparam int QueueFillBits = $clog2(QueueDepth + 1);

   // Token kinds
   localparam logic [KindBits-1:0] KIND_NAME     = 5'd0;
   localparam logic [KindBits-1:0] KIND_INT      = 5'd1;
   localparam logic [KindBits-1:0] KIND_STRING   = 5'd2;
   localparam logic [KindBits-1:0] KIND_BLOCK    = 5'd3;
   localparam logic [KindBits-1:0] KIND_LBRACE   = 5'd4;
   localparam logic [KindBits-1:0] KIND_RBRACE   = 5'd5;
   localparam logic [KindBits-1:0] KIND_LBRACKET = 5'd6;
   localparam logic [KindBits-1:0] KIND_RBRACKET = 5'd7;
   localparam logic [KindBits-1:0] KIND_LPAREN   = 5'd8;
   localparam logic [KindBits-1:0] KIND_RPAREN   = 5'd9;
   localparam logic [KindBits-1:0] KIND_COLON    = 5'd10;
   localparam logic [KindBits-1:0] KIND_BANG     = 5'd11;
   localparam logic [KindBits-1:0] KIND_AMP      = 5'd12;
   localparam logic [KindBits-1:0] KIND_SPREAD   = 5'd13;
   localparam logic [KindBits-1:0] KIND_EQUALS   = 5'd14;
   localparam logic [KindBits-1:0] KIND_PIPE     = 5'd15;
   localparam logic [KindBits-1:0] KIND_AT       = 5'd16;
   localparam logic [KindBits-1:0] KIND_END      = 5'd17;
   localparam logic [KindBits-1:0] KIND_INVALID  = 5'd18;

   // Character codes
   localparam logic [7:0] CHAR_QUOTE    = 8'h22;
   localparam logic [7:0] CHAR_UNDER    = 8'h5F;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_ZERO     = 8'h30;
   localparam logic [7:0] CHAR_NINE     = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
   localparam logic [7:0] CHAR_DOT      = 8'h2E;
   localparam logic [7:0] CHAR_HASH     = 8'h23;
   localparam logic [7:0] CHAR_LBRACE   = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE   = 8'h7D;
   localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
   localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
   localparam logic [7:0] CHAR_LPAREN   = 8'h28;
   localparam logic [7:0] CHAR_RPAREN   = 8'h29;
   localparam logic [7:0] CHAR_COLON    = 8'h3A;
   localparam logic [7:0] CHAR_BANG     = 8'h21;
   localparam logic [7:0] CHAR_AMP      = 8'h26;
   localparam logic [7:0] CHAR_EQUALS   = 8'h3D;
   localparam logic [7:0] CHAR_PIPE     = 8'h7C;
   localparam logic [7:0] CHAR_AT       = 8'h40;

   // Scanner modes
   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_NAME    = 4'd1,
      MODE_INT     = 4'd2,
      MODE_COMMENT = 4'd3,
      MODE_DOT1    = 4'd4,
      MODE_DOT2    = 4'd5,
      MODE_QUOTE1  = 4'd6,
      MODE_QUOTE2  = 4'd7,
      MODE_STRING  = 4'd8,
      MODE_BLOCK   = 4'd9
   } mode_type;

   typedef struct packed {
      logic [FieldBits-1:0] length;
      logic [FieldBits-1:0] offset;
      logic [KindBits-1:0]  kind;
   } token_type;

   // All tokens caused by one input byte, in emission order from slot 0
   typedef struct packed {
      logic [CountBits-1:0]            count;
      token_type [MaxTokens-1:0]       tok;
   } bundle_type;

   typedef struct packed {
      logic                     full;
      logic                     empty;
      logic [QueueFillBits-1:0] fill;
   } queue_status_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   endfunction

   function automatic logic is_name_start(input logic [7:0] b);
      return ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ||
             ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z)) || (b == CHAR_UNDER);
   endfunction

   function automatic logic is_punct(input logic [7:0] b);
      logic hit;
      case (b)
         CHAR_LBRACE, CHAR_RBRACE, CHAR_LBRACKET, CHAR_RBRACKET, CHAR_LPAREN,
         CHAR_RPAREN, CHAR_COLON, CHAR_BANG, CHAR_AMP, CHAR_EQUALS, CHAR_PIPE,
         CHAR_AT: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic [KindBits-1:0] punct_kind(input logic [7:0] b);
      logic [KindBits-1:0] k;
      case (b)
         CHAR_LBRACE:   k = KIND_LBRACE;
         CHAR_RBRACE:   k = KIND_RBRACE;
         CHAR_LBRACKET: k = KIND_LBRACKET;
         CHAR_RBRACKET: k = KIND_RBRACKET;
         CHAR_LPAREN:   k = KIND_LPAREN;
         CHAR_RPAREN:   k = KIND_RPAREN;
         CHAR_COLON:    k = KIND_COLON;
         CHAR_BANG:     k = KIND_BANG;
         CHAR_AMP:      k = KIND_AMP;
         CHAR_EQUALS:   k = KIND_EQUALS;
         CHAR_PIPE:     k = KIND_PIPE;
         CHAR_AT:       k = KIND_AT;
         default:       k = KIND_INVALID;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/qtl_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Lexer front: scanner state and per-byte classification into a token bundle
module qtl_front #(
   parameter int POSITION_BITS = qtl_pkg::PositionBitsDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic                 in_ready,
   input  wire logic [7:0]           text_byte,
   input  wire logic                 end_of_text,
   output logic                      push_valid,
   output qtl_pkg::bundle_type       push_bundle
);

   localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};
   localparam logic [POSITION_BITS-1:0] PosOne = POSITION_BITS'(1);

   qtl_pkg::mode_type          mode_ff, mode_in;
   logic [POSITION_BITS-1:0]   pos_ff, pos_in;
   logic [POSITION_BITS-1:0]   start_ff, start_in;
   logic [1:0]                 quote_ff, quote_in;

   logic                       accept;
   logic [POSITION_BITS-1:0]   pos_next;
   logic [1:0]                 quote_inc;

   // Outcome of lexing the byte with nothing pending
   qtl_pkg::mode_type          il_mode;
   logic                       il_set_start;
   logic [POSITION_BITS-1:0]   il_start;
   logic                       il_tok_valid;
   qtl_pkg::token_type         il_tok;

   logic                       use_idle;
   logic [1:0]                 pre_n;
   qtl_pkg::token_type         pre0, pre1;
   logic                       extra_valid;
   qtl_pkg::token_type         extra;

   function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
      return (v == PosMax) ? v : v + PosOne;
   endfunction

   function automatic logic [POSITION_BITS-1:0] sub_floor(
      input logic [POSITION_BITS-1:0] a,
      input logic [POSITION_BITS-1:0] b
   );
      return (a > b) ? a - b : '0;
   endfunction

   // Offsets and lengths leave as 20-bit fields whatever the counter width
   function automatic qtl_pkg::token_type make_tok(
      input logic [qtl_pkg::KindBits-1:0] k,
      input logic [POSITION_BITS-1:0]     off,
      input logic [POSITION_BITS-1:0]     len
   );
      logic [POSITION_BITS+qtl_pkg::FieldBits-1:0] off_ext;
      logic [POSITION_BITS+qtl_pkg::FieldBits-1:0] len_ext;
      qtl_pkg::token_type t;
      off_ext  = {{qtl_pkg::FieldBits{1'b0}}, off};
      len_ext  = {{qtl_pkg::FieldBits{1'b0}}, len};
      t.kind   = k;
      t.offset = off_ext[qtl_pkg::FieldBits-1:0];
      t.length = len_ext[qtl_pkg::FieldBits-1:0];
      return t;
   endfunction

   assign accept    = in_valid && in_ready;
   assign pos_next  = sat_inc(pos_ff);
   assign quote_inc = quote_ff + 2'd1;

   // Idle-mode classification of the incoming byte
   always_comb begin
      il_mode      = qtl_pkg::MODE_IDLE;
      il_set_start = 1'b0;
      il_start     = pos_ff;
      il_tok_valid = 1'b0;
      il_tok       = make_tok(qtl_pkg::punct_kind(text_byte), pos_ff, PosOne);
      if (qtl_pkg::is_digit(text_byte)) begin
         il_mode      = qtl_pkg::MODE_INT;
         il_set_start = 1'b1;
      end else if (qtl_pkg::is_name_start(text_byte)) begin
         il_mode      = qtl_pkg::MODE_NAME;
         il_set_start = 1'b1;
      end else if (qtl_pkg::is_punct(text_byte)) begin
         il_tok_valid = 1'b1;
      end else if (text_byte == qtl_pkg::CHAR_DOT) begin
         il_mode      = qtl_pkg::MODE_DOT1;
         il_set_start = 1'b1;
      end else if (text_byte == qtl_pkg::CHAR_HASH) begin
         il_mode      = qtl_pkg::MODE_COMMENT;
      end else if (text_byte == qtl_pkg::CHAR_QUOTE) begin
         il_mode      = qtl_pkg::MODE_QUOTE1;
         il_set_start = 1'b1;
         il_start     = pos_next;
      end
   end

   // Pending-token handling and next state
   always_comb begin
      mode_in     = mode_ff;
      pos_in      = pos_next;
      start_in    = start_ff;
      quote_in    = quote_ff;
      use_idle    = 1'b0;
      pre_n       = 2'd0;
      pre0        = make_tok(qtl_pkg::KIND_INVALID, start_ff, PosOne);
      pre1        = make_tok(qtl_pkg::KIND_INVALID, sat_inc(start_ff), PosOne);
      extra_valid = 1'b0;
      extra       = il_tok;

      if (end_of_text) begin
         case (mode_ff)
            qtl_pkg::MODE_NAME: begin
               pre_n = 2'd1;
               pre0  = make_tok(qtl_pkg::KIND_NAME, start_ff, sub_floor(pos_ff, start_ff));
            end
            qtl_pkg::MODE_INT: begin
               pre_n = 2'd1;
               pre0  = make_tok(qtl_pkg::KIND_INT, start_ff, sub_floor(pos_ff, start_ff));
            end
            qtl_pkg::MODE_DOT1: pre_n = 2'd1;
            qtl_pkg::MODE_DOT2: pre_n = 2'd2;
            qtl_pkg::MODE_QUOTE1, qtl_pkg::MODE_QUOTE2: begin
               pre_n = 2'd1;
               pre0  = make_tok(qtl_pkg::KIND_STRING, start_ff, '0);
            end
            qtl_pkg::MODE_STRING: begin
               pre_n = 2'd1;
               pre0  = make_tok(qtl_pkg::KIND_STRING, start_ff, sub_floor(pos_ff, start_ff));
            end
            qtl_pkg::MODE_BLOCK: begin
               pre_n = 2'd1;
               pre0  = make_tok(qtl_pkg::KIND_BLOCK, start_ff, sub_floor(pos_ff, start_ff));
            end
            default: pre_n = 2'd0;
         endcase
         extra_valid = 1'b1;
         extra       = make_tok(qtl_pkg::KIND_END, pos_ff, '0);
         mode_in     = qtl_pkg::MODE_IDLE;
         pos_in      = '0;
         start_in    = '0;
         quote_in    = 2'd0;
      end else begin
         case (mode_ff)
            qtl_pkg::MODE_NAME: begin
               if (!(qtl_pkg::is_name_start(text_byte) || qtl_pkg::is_digit(text_byte))) begin
                  pre_n    = 2'd1;
                  pre0     = make_tok(qtl_pkg::KIND_NAME, start_ff,
                                      sub_floor(pos_ff, start_ff));
                  use_idle = 1'b1;
               end
            end
            qtl_pkg::MODE_INT: begin
               if (!qtl_pkg::is_digit(text_byte)) begin
                  pre_n    = 2'd1;
                  pre0     = make_tok(qtl_pkg::KIND_INT, start_ff,
                                      sub_floor(pos_ff, start_ff));
                  use_idle = 1'b1;
               end
            end
            qtl_pkg::MODE_COMMENT: begin
               if (text_byte == qtl_pkg::CHAR_LF || text_byte == qtl_pkg::CHAR_CR) begin
                  mode_in = qtl_pkg::MODE_IDLE;
               end
            end
            qtl_pkg::MODE_DOT1: begin
               if (text_byte == qtl_pkg::CHAR_DOT) begin
                  mode_in = qtl_pkg::MODE_DOT2;
               end else begin
                  pre_n    = 2'd1;
                  use_idle = 1'b1;
               end
            end
            qtl_pkg::MODE_DOT2: begin
               if (text_byte == qtl_pkg::CHAR_DOT) begin
                  pre_n   = 2'd1;
                  pre0    = make_tok(qtl_pkg::KIND_SPREAD, start_ff, POSITION_BITS'(3));
                  mode_in = qtl_pkg::MODE_IDLE;
               end else begin
                  pre_n    = 2'd2;
                  use_idle = 1'b1;
               end
            end
            qtl_pkg::MODE_QUOTE1: begin
               mode_in = (text_byte == qtl_pkg::CHAR_QUOTE) ? qtl_pkg::MODE_QUOTE2
                                                            : qtl_pkg::MODE_STRING;
            end
            qtl_pkg::MODE_QUOTE2: begin
               if (text_byte == qtl_pkg::CHAR_QUOTE) begin
                  mode_in  = qtl_pkg::MODE_BLOCK;
                  start_in = pos_next;
                  quote_in = 2'd0;
               end else begin
                  // two quotes then something else: empty string
                  pre_n    = 2'd1;
                  pre0     = make_tok(qtl_pkg::KIND_STRING, start_ff, '0);
                  use_idle = 1'b1;
               end
            end
            qtl_pkg::MODE_STRING: begin
               if (text_byte == qtl_pkg::CHAR_QUOTE) begin
                  pre_n   = 2'd1;
                  pre0    = make_tok(qtl_pkg::KIND_STRING, start_ff,
                                     sub_floor(pos_ff, start_ff));
                  mode_in = qtl_pkg::MODE_IDLE;
               end
            end
            qtl_pkg::MODE_BLOCK: begin
               if (text_byte == qtl_pkg::CHAR_QUOTE) begin
                  if (quote_inc == 2'd3) begin
                     pre_n    = 2'd1;
                     pre0     = make_tok(qtl_pkg::KIND_BLOCK, start_ff,
                                         sub_floor(sub_floor(pos_ff, POSITION_BITS'(2)),
                                                   start_ff));
                     mode_in  = qtl_pkg::MODE_IDLE;
                     quote_in = 2'd0;
                  end else begin
                     quote_in = quote_inc;
                  end
               end else begin
                  quote_in = 2'd0;
               end
            end
            default: use_idle = 1'b1;
         endcase

         if (use_idle) begin
            mode_in     = il_mode;
            extra_valid = il_tok_valid;
            if (il_set_start) begin
               start_in = il_start;
            end
         end
      end
   end

   // Pack the bundle: pending tokens first, then the trailing one
   always_comb begin
      push_bundle.count  = pre_n + {1'b0, extra_valid};
      push_bundle.tok[0] = (pre_n == 2'd0) ? extra : pre0;
      push_bundle.tok[1] = (pre_n == 2'd1) ? extra : pre1;
      push_bundle.tok[2] = extra;
   end

   assign push_valid = accept && (push_bundle.count != '0);

   // Scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= qtl_pkg::MODE_IDLE;
         pos_ff   <= '0;
         start_ff <= '0;
         quote_ff <= 2'd0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         quote_ff <= quote_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/qtl_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Short bundle queue between the front and the back end
module qtl_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire qtl_pkg::bundle_type        push_data,
   input  wire logic                       pop,
   output qtl_pkg::bundle_type             head,
   output qtl_pkg::queue_status_type       status
);

   qtl_pkg::bundle_type                       slot_ff [qtl_pkg::QueueDepth];
   logic [qtl_pkg::QueuePtrBits-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [qtl_pkg::QueuePtrBits-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [qtl_pkg::QueueFillBits-1:0]         fill_ff, fill_in;
   logic                                      do_push, do_pop;

   assign status.fill  = fill_ff;
   assign status.empty = (fill_ff == '0);
   assign status.full  = (fill_ff == qtl_pkg::QueueFillBits'(qtl_pkg::QueueDepth));

   assign do_push = push && !status.full;
   assign do_pop  = pop && !status.empty;
   assign head    = slot_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + qtl_pkg::QueuePtrBits'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + qtl_pkg::QueuePtrBits'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + qtl_pkg::QueueFillBits'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - qtl_pkg::QueueFillBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/qtl_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Back end: moves head tokens to the output register, one per cycle unless stalled
module qtl_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire qtl_pkg::bundle_type                 head,
   input  wire logic                                head_valid,
   output logic                                     pop,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [qtl_pkg::RspDataBits-1:0]          rsp_tdata,
   output logic                                     rsp_tlast
);

   logic [qtl_pkg::CountBits-1:0] idx_ff, idx_in;
   logic                          out_valid_ff, out_valid_in;
   qtl_pkg::token_type            out_tok_ff;
   logic                          out_last_ff;
   logic                          load;
   logic                          tok_last;

   // Move a token whenever the output register is free or being drained
   assign load     = head_valid && (!out_valid_ff || rsp_tready);
   assign tok_last = (idx_ff == head.count - qtl_pkg::CountBits'(1));
   assign pop      = load && tok_last;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (load) begin
         idx_in       = tok_last ? '0 : idx_ff + qtl_pkg::CountBits'(1);
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (load) begin
         out_tok_ff  <= head.tok[idx_ff];
         out_last_ff <= tok_last;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(qtl_pkg::RspDataBits - $bits(qtl_pkg::token_type)){1'b0}},
                        out_tok_ff};

endmodule

`default_nettype wire

// ----- rtl/query_token_lexer_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Streaming query lexer. Feed the query one byte per transfer on req_, with
// req_tlast high on a closing transfer that carries no byte: it flushes any
// pending token, emits the end token and rewinds the position to zero. Tokens
// come out on rsp_ as kind, offset and length, with rsp_tlast on the last
// token caused by one input transfer. The front takes one byte every cycle
// unless the bundle queue is full; each token leaves the output register in
// a cycle of its own. A byte that closes one token and opens a punctuator, a
// stray double dot or the end marker yields two or three tokens, which the
// four-entry queue absorbs. A byte's first token is registered in the queue,
// then in the output register. No clearing pass after reset.
module query_token_lexer_core #(
   parameter int POSITION_BITS = qtl_pkg::PositionBitsDefault
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [qtl_pkg::ReqDataBits-1:0]    req_tdata,   // [7:0] text_byte
   input  wire logic                               req_tlast,   // end_of_text
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [4:0] token_kind, [24:5] token_offset, [44:25] token_length, [47:45] zero
   output logic [qtl_pkg::RspDataBits-1:0]         rsp_tdata,
   output logic                                    rsp_tlast    // last_of_run
);

   logic                        push_valid;
   qtl_pkg::bundle_type         push_bundle;
   logic                        pop;
   qtl_pkg::bundle_type         head;
   qtl_pkg::queue_status_type   queue_status;

   assign req_tready = !queue_status.full;

   qtl_front #(
      .POSITION_BITS (POSITION_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .push_valid  (push_valid),
      .push_bundle (push_bundle)
   );

   qtl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data (push_bundle),
      .pop       (pop),
      .head      (head),
      .status    (queue_status)
   );

   qtl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_valid (!queue_status.empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // A closing transfer always queues at least the end token
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |-> push_valid)
      else $error("end of text accepted without queuing a bundle");

   // Nothing appears at the output while the queue is empty
   assert property (@(posedge clock) disable iff (reset)
      (queue_status.empty && !rsp_tvalid) |=> !rsp_tvalid)
      else $error("token emitted with no bundle queued");

   // The queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      queue_status.fill <= qtl_pkg::QueueFillBits'(qtl_pkg::QueueDepth))
      else $error("bundle queue fill beyond depth");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import qtl_pkg::*;

   // Position counter width for the block under test
   localparam int PosBits = 8;
   localparam longint unsigned PosMax = (64'd1 << PosBits) - 1;
   localparam int WatchLimit = 2000;
   localparam int ItemTarget = 120;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;

   typedef struct {
      logic [KindBits-1:0]  kind;
      logic [FieldBits-1:0] offset;
      logic [FieldBits-1:0] length;
      logic                 last;
   } token_rec;

   // Token predictor plus the queue of tokens still owed by the block
   class token_scoreboard;
      mode_type        mode = MODE_IDLE;
      longint unsigned pos = 0;
      longint unsigned start = 0;
      logic [1:0]      quote_count = 2'd0;
      token_rec        step_tokens[$];
      token_rec        expected_tokens[$];
      int              errors = 0;

      function void clear_state();
         mode = MODE_IDLE;
         pos = 0;
         start = 0;
         quote_count = 2'd0;
      endfunction

      function longint unsigned bump(longint unsigned v);
         return (v >= PosMax) ? PosMax : v + 1;
      endfunction

      function longint unsigned shrink(longint unsigned a, longint unsigned b);
         return (a > b) ? a - b : 0;
      endfunction

      function bit digit_byte(logic [7:0] b);
         return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
      endfunction

      function bit name_head(logic [7:0] b);
         return ((b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) ||
                ((b >= CHAR_LOWER_A) && (b <= CHAR_LOWER_Z)) || (b == CHAR_UNDER);
      endfunction

      function bit punct_of(logic [7:0] b, output logic [KindBits-1:0] kind);
         punct_of = 1'b1;
         case (b)
            CHAR_LBRACE:   kind = KIND_LBRACE;
            CHAR_RBRACE:   kind = KIND_RBRACE;
            CHAR_LBRACKET: kind = KIND_LBRACKET;
            CHAR_RBRACKET: kind = KIND_RBRACKET;
            CHAR_LPAREN:   kind = KIND_LPAREN;
            CHAR_RPAREN:   kind = KIND_RPAREN;
            CHAR_COLON:    kind = KIND_COLON;
            CHAR_BANG:     kind = KIND_BANG;
            CHAR_AMP:      kind = KIND_AMP;
            CHAR_EQUALS:   kind = KIND_EQUALS;
            CHAR_PIPE:     kind = KIND_PIPE;
            CHAR_AT:       kind = KIND_AT;
            default: begin
               kind = KIND_INVALID;
               punct_of = 1'b0;
            end
         endcase
      endfunction

      function void add_token(logic [KindBits-1:0] kind, longint unsigned off,
                              longint unsigned len);
         token_rec t;
         if (step_tokens.size() < MaxTokens) begin
            t.kind = kind;
            t.offset = off[FieldBits-1:0];
            t.length = len[FieldBits-1:0];
            t.last = 1'b0;
            step_tokens.push_back(t);
         end
      endfunction

      // Byte seen with nothing pending
      function void open_token(logic [7:0] b);
         logic [KindBits-1:0] pk;
         mode = MODE_IDLE;
         if (digit_byte(b)) begin
            mode = MODE_INT;
            start = pos;
         end else if (name_head(b)) begin
            mode = MODE_NAME;
            start = pos;
         end else if (punct_of(b, pk)) begin
            add_token(pk, pos, 1);
         end else if (b == CHAR_DOT) begin
            mode = MODE_DOT1;
            start = pos;
         end else if (b == CHAR_HASH) begin
            mode = MODE_COMMENT;
         end else if (b == CHAR_QUOTE) begin
            mode = MODE_QUOTE1;
            start = bump(pos);
         end
      endfunction

      // One accepted input transfer: predict the tokens it causes
      function void note_byte(logic [7:0] b, logic fin);
         longint unsigned p;
         p = pos;
         step_tokens.delete();
         if (fin) begin
            case (mode)
               MODE_NAME:   add_token(KIND_NAME, start, shrink(p, start));
               MODE_INT:    add_token(KIND_INT, start, shrink(p, start));
               MODE_DOT1:   add_token(KIND_INVALID, start, 1);
               MODE_DOT2: begin
                  add_token(KIND_INVALID, start, 1);
                  add_token(KIND_INVALID, bump(start), 1);
               end
               MODE_QUOTE1, MODE_QUOTE2: add_token(KIND_STRING, start, 0);
               MODE_STRING: add_token(KIND_STRING, start, shrink(p, start));
               MODE_BLOCK:  add_token(KIND_BLOCK, start, shrink(p, start));
               default: ;
            endcase
            add_token(KIND_END, p, 0);
            clear_state();
         end else begin
            case (mode)
               MODE_NAME: begin
                  if (!(name_head(b) || digit_byte(b))) begin
                     add_token(KIND_NAME, start, shrink(p, start));
                     open_token(b);
                  end
               end
               MODE_INT: begin
                  if (!digit_byte(b)) begin
                     add_token(KIND_INT, start, shrink(p, start));
                     open_token(b);
                  end
               end
               MODE_COMMENT: begin
                  if (b == CHAR_LF || b == CHAR_CR) mode = MODE_IDLE;
               end
               MODE_DOT1: begin
                  if (b == CHAR_DOT) begin
                     mode = MODE_DOT2;
                  end else begin
                     add_token(KIND_INVALID, start, 1);
                     open_token(b);
                  end
               end
               MODE_DOT2: begin
                  if (b == CHAR_DOT) begin
                     add_token(KIND_SPREAD, start, 3);
                     mode = MODE_IDLE;
                  end else begin
                     add_token(KIND_INVALID, start, 1);
                     add_token(KIND_INVALID, bump(start), 1);
                     open_token(b);
                  end
               end
               MODE_QUOTE1: mode = (b == CHAR_QUOTE) ? MODE_QUOTE2 : MODE_STRING;
               MODE_QUOTE2: begin
                  if (b == CHAR_QUOTE) begin
                     mode = MODE_BLOCK;
                     start = bump(p);
                     quote_count = 2'd0;
                  end else begin
                     add_token(KIND_STRING, start, 0);
                     open_token(b);
                  end
               end
               MODE_STRING: begin
                  if (b == CHAR_QUOTE) begin
                     add_token(KIND_STRING, start, shrink(p, start));
                     mode = MODE_IDLE;
                  end
               end
               MODE_BLOCK: begin
                  // closing run of three quotes is not part of the value
                  if (b == CHAR_QUOTE) begin
                     quote_count = quote_count + 2'd1;
                     if (quote_count == 2'd3) begin
                        add_token(KIND_BLOCK, start, shrink(shrink(p, 2), start));
                        mode = MODE_IDLE;
                        quote_count = 2'd0;
                     end
                  end else begin
                     quote_count = 2'd0;
                  end
               end
               default: open_token(b);
            endcase
            pos = bump(p);
         end
         if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
         foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
      endfunction

      function void compare(string field, longint unsigned want, longint unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: token %s expected %0d, got %0d", $time, field, want, got);
         end
      endfunction

      // One accepted output transfer against the oldest predicted token
      function void check_token(logic [RspDataBits-1:0] data, logic last);
         token_rec want;
         if (expected_tokens.size() == 0) begin
            errors++;
            $display("%0t: token expected none, got %h last %0d", $time, data, last);
            return;
         end
         want = expected_tokens.pop_front();
         compare("kind", want.kind, data[KindBits-1:0]);
         compare("offset", want.offset, data[KindBits+FieldBits-1:KindBits]);
         compare("length", want.length, data[KindBits+2*FieldBits-1:KindBits+FieldBits]);
         compare("padding", 0, data[RspDataBits-1:KindBits+2*FieldBits]);
         compare("last", want.last, last);
      endfunction

      function int waiting();
         return expected_tokens.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [ReqDataBits-1:0] req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RspDataBits-1:0] rsp_tdata;
   logic                   rsp_tlast;

   token_scoreboard sb;
   bit  send_calm = 1'b0;
   bit  rsp_calm = 1'b0;
   int  hold_left = 0;
   int  idle_cycles = 0;
   int  counted = 0;

   logic [7:0] punct_chars [12] = '{CHAR_LBRACE, CHAR_RBRACE, CHAR_LBRACKET,
      CHAR_RBRACKET, CHAR_LPAREN, CHAR_RPAREN, CHAR_COLON, CHAR_BANG, CHAR_AMP,
      CHAR_EQUALS, CHAR_PIPE, CHAR_AT};
   logic [7:0] sep_chars [4] = '{CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_COMMA};

   query_token_lexer_core #(
      .POSITION_BITS(PosBits)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always #4 clock = ~clock;

   // Monitor both channels and watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_byte(req_tdata[7:0], req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_token(rsp_tdata, rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WatchLimit) begin
            $display("Verification failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Output backpressure: mostly short holds, a few long, calm stretches
   always @(posedge clock) begin
      if ($urandom_range(0, 149) == 0) rsp_calm <= ~rsp_calm;
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!rsp_calm && $urandom_range(0, 99) < 30) begin
            hold_left <= ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                      : $urandom_range(8, 30);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (send_calm || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_item(input logic [7:0] b, input logic fin);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= fin;
      do @(posedge clock); while (!req_tready);
      counted++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
   endtask

   // Byte on the closing transfer is random: the block must ignore it
   task automatic send_end();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   function automatic logic [7:0] name_char(input bit head);
      int r;
      r = head ? $urandom_range(0, 52) : $urandom_range(0, 62);
      if (r < 26) return CHAR_UPPER_A + 8'(r);
      if (r < 52) return CHAR_LOWER_A + 8'(r - 26);
      if (r == 52) return CHAR_UNDER;
      return CHAR_ZERO + 8'(r - 53);
   endfunction

   function automatic logic [7:0] body_byte(input bit in_comment);
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (in_comment ? (b == CHAR_LF || b == CHAR_CR) : (b == CHAR_QUOTE));
      return b;
   endfunction

   // Mostly well-formed token fragments with random content, some noise
   task automatic random_query();
      int pieces, n;
      pieces = $urandom_range(1, 10);
      send_calm = ($urandom_range(0, 4) == 0);
      repeat (pieces) begin
         case ($urandom_range(0, 11))
            0: begin
               send_item(name_char(1'b1), 1'b0);
               n = $urandom_range(0, 5);
               repeat (n) send_item(name_char(1'b0), 1'b0);
            end
            1: begin
               n = $urandom_range(1, 4);
               repeat (n) send_item(CHAR_ZERO + 8'($urandom_range(0, 9)), 1'b0);
            end
            2: send_item(punct_chars[$urandom_range(0, 11)], 1'b0);
            3: send_text("...");
            4: begin
               n = $urandom_range(1, 2);
               repeat (n) send_item(CHAR_DOT, 1'b0);
            end
            5: begin
               send_item(CHAR_QUOTE, 1'b0);
               n = $urandom_range(0, 5);
               repeat (n) send_item(body_byte(1'b0), 1'b0);
               send_item(CHAR_QUOTE, 1'b0);
            end
            6: begin
               send_text("\"\"\"");
               n = $urandom_range(0, 6);
               repeat (n) send_item(8'($urandom_range(0, 255)), 1'b0);
               send_text("\"\"\"");
            end
            7: send_text("\"\"");
            8: begin
               send_item(CHAR_HASH, 1'b0);
               n = $urandom_range(0, 5);
               repeat (n) send_item(body_byte(1'b1), 1'b0);
               send_item($urandom_range(0, 1) ? CHAR_LF : CHAR_CR, 1'b0);
            end
            9: send_item(sep_chars[$urandom_range(0, 3)], 1'b0);
            10: send_item(8'($urandom_range(0, 255)), 1'b0);
            default: begin
               // opening quotes left without their close
               n = $urandom_range(1, 2);
               repeat (n) send_item(CHAR_QUOTE, 1'b0);
               n = $urandom_range(0, 3);
               repeat (n) send_item(body_byte(1'b0), 1'b0);
            end
         endcase
         if ($urandom_range(0, 9) < 6) send_item(sep_chars[$urandom_range(0, 3)], 1'b0);
      end
      send_end();
   endtask

   initial begin
      sb = new;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // All punctuators, name and int, stray double dot, empty string,
      // block string with inner quotes, spread, string open at the end
      send_text("{}[]():!&=|@A_z9,09 ..\"\" \"\"\"b\"\"q\"\"\"...\"x");
      send_end();
      // Pending states flushed by end of text, and an empty query
      send_text(".");
      send_end();
      send_text("..");
      send_end();
      send_text("\"\"");
      send_end();
      send_text("#");
      send_end();
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_text("7");
      send_end();
      send_text("\"\"\"ab");
      send_end();
      send_end();

      // Comment closed by a newline, then a mixed run of tokens
      send_text("a#");
      repeat (5) send_item(body_byte(1'b1), 1'b0);
      send_text("\nab ..{\"q\"\"\"x\"\"\"1");
      send_end();

      while (counted < ItemTarget) random_query();
      req_tvalid <= 1'b0;

      while (sb.waiting() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
